// File: design/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and constants of the diamond-square heightmap generator.
// ----------------------------------------------------------------------------
package dsh_pkg;

  localparam int unsigned MaxLogDefault = 8;
  // Width of the running neighbor total (sum of four Q24.8 heights plus offset).
  localparam int unsigned TotW          = 36;

  localparam logic [1:0] CfgSizeLog   = 2'd0;
  localparam logic [1:0] CfgRoughness = 2'd1;

  localparam logic [1:0] PhSeed    = 2'd0;
  localparam logic [1:0] PhSquare  = 2'd1;
  localparam logic [1:0] PhDiamond = 2'd2;

  localparam logic [3:0] SizeLogReset   = 4'd6;
  localparam logic [3:0] SizeLogMin     = 4'd2;
  localparam logic [15:0] RoughReset    = 16'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// File: design/diamond_square_heightmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap
// Diamond-square heightmap generator, one map point written per input item.
// ----------------------------------------------------------------------------
// Order: a corner result is loaded into the output register after its seed step;
//   a walked point after the read slots through the single map port, the two
//   multiplies, the add, the divide and the write-back.
// Flow: one item at a time, the next taken only after the last is written back,
//   and later while the output register still waits on the receiver.
// Reset: all walk state and marks cleared to their start values; the map RAM is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module diamond_square_heightmap #(
  parameter int unsigned MAX_LOG = dsh_pkg::MaxLogDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input item
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        sample_i,
  // result item
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [8:0]         col_o,
  output logic [8:0]         row_o,
  output logic signed [31:0] height_o,
  output logic signed [31:0] low_mark_o,
  output logic signed [31:0] high_mark_o,
  output logic               run_done_o
);

  localparam int unsigned CW    = MAX_LOG + 1;         // coordinate width
  localparam int unsigned EW    = CW + 1;              // coordinate math width
  localparam int unsigned HW    = MAX_LOG;             // half step width
  localparam int unsigned Side  = (2 ** MAX_LOG) + 1;
  localparam int unsigned Depth = Side * Side;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned P1W   = 16 + HW;
  localparam int unsigned P2W   = P1W + 17;
  localparam int unsigned MW    = P2W - 20;
  localparam int unsigned TW    = dsh_pkg::TotW;

  localparam logic signed [31:0] HMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] HMin = 32'sh8000_0000;

  dsh_pkg::state_e state_q, state_d;

  logic [3:0]          size_log_q, size_log_d;
  logic [15:0]         rough_q, rough_d;
  logic [HW-1:0]       hs_q, hs_d;
  logic [1:0]          phase_q, phase_d;
  logic [CW-1:0]       col_q, col_d, row_q, row_d;
  logic                seeded_q, seeded_d;
  logic signed [31:0]  min_q, min_d, max_q, max_d;

  logic [15:0]         u_q, u_d;
  logic [2:0]          nb_q, nb_d;
  logic                pend_q, pend_d;
  logic signed [TW-1:0] sum_q, sum_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [P1W-1:0]      prod1_q, prod1_d;
  logic [P2W-1:0]      prod2_q, prod2_d;
  logic [16:0]         absd_q, absd_d;
  logic                neg_q, neg_d;
  logic signed [TW-1:0] tot_q, tot_d;
  logic signed [31:0]  h_q, h_d;

  logic                ov_q, ov_d;
  logic [8:0]          oc_q, oc_d, or_q, or_d;
  logic signed [31:0]  oh_q, oh_d, olo_q, olo_d, ohi_q, ohi_d;
  logic                odone_q, odone_d;

  // map RAM, single port, registered read
  logic signed [31:0]  heights [Depth];
  logic signed [31:0]  rd_q;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;

  logic [CW-1:0]       side;
  logic [EW-1:0]       xe, ze, hse, ne;
  logic [EW-1:0]       nbx, nby;
  logic                nb_ok;
  logic                div_start, div_done;
  logic [TW-1:0]       div_quo;

  assign side = CW'((CW'(1) << size_log_q) + CW'(1));
  assign xe   = EW'(col_q);
  assign ze   = EW'(row_q);
  assign hse  = EW'(hs_q);
  assign ne   = EW'(side);

  // neighbor candidate for the current read slot
  always_comb begin
    logic [1:0] k;
    k     = nb_q[1:0];
    nbx   = xe;
    nby   = ze;
    nb_ok = 1'b0;
    if (phase_q == dsh_pkg::PhSquare) begin
      nbx   = k[1] ? xe + hse : xe - hse;
      nby   = k[0] ? ze + hse : ze - hse;
      nb_ok = (k[1] ? (xe + hse < ne) : (xe >= hse)) &&
              (k[0] ? (ze + hse < ne) : (ze >= hse));
    end else begin
      unique case (k)
        2'd0: begin nbx = xe - hse; nb_ok = (xe >= hse);     end
        2'd1: begin nbx = xe + hse; nb_ok = (xe + hse < ne); end
        2'd2: begin nby = ze - hse; nb_ok = (ze >= hse);     end
        default: begin nby = ze + hse; nb_ok = (ze + hse < ne); end
      endcase
    end
  end

  // address = row * side + col, side = 2^L + 1
  always_comb begin
    logic [2*EW-1:0] a;
    logic [EW-1:0]   ax, ay;
    ax = (state_q == dsh_pkg::ST_READ) ? nbx : xe;
    ay = (state_q == dsh_pkg::ST_READ) ? nby : ze;
    a  = ((2*EW)'(ay) << size_log_q) + (2*EW)'(ay) + (2*EW)'(ax);
    mem_addr = a[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heights[mem_addr] <= h_q;
    end
    rd_q <= heights[mem_addr];
  end

  // the total is handed over in the add cycle, as it is formed
  dsh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (tot_d),
    .dvs_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    logic [3:0]           lnew;
    logic signed [TW:0]   val;
    logic [TW-1:0]        offm;
    logic signed [31:0]   nmin, nmax;
    logic [EW-1:0]        ncol;
    state_d    = state_q;
    size_log_d = size_log_q;
    rough_d    = rough_q;
    hs_d       = hs_q;
    phase_d    = phase_q;
    col_d      = col_q;
    row_d      = row_q;
    seeded_d   = seeded_q;
    min_d      = min_q;
    max_d      = max_q;
    u_d        = u_q;
    nb_d       = nb_q;
    pend_d     = 1'b0;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    prod1_d    = prod1_q;
    prod2_d    = prod2_q;
    absd_d     = absd_q;
    neg_d      = neg_q;
    tot_d      = tot_q;
    h_d        = h_q;
    ov_d       = ov_q && !out_ready_i;
    oc_d       = oc_q;
    or_d       = or_q;
    oh_d       = oh_q;
    olo_d      = olo_q;
    ohi_d      = ohi_q;
    odone_d    = odone_q;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    // a pending register write goes first
    in_ready_o = (state_q == dsh_pkg::ST_IDLE) && !cfg_valid_i;
    lnew       = '0;
    val        = '0;
    offm       = '0;
    nmin       = min_q;
    nmax       = max_q;
    ncol       = '0;

    if (pend_q) begin
      sum_d = sum_q + TW'(rd_q);
    end

    unique case (state_q)
      dsh_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          u_d    = sample_i;
          nb_d   = '0;
          sum_d  = '0;
          cnt_d  = '0;
          state_d = (phase_q == dsh_pkg::PhSeed) ? dsh_pkg::ST_SEED : dsh_pkg::ST_READ;
        end
      end
      dsh_pkg::ST_SEED: begin
        h_d     = 32'((({16'd0, u_q} * 32'(side)) >> 8));
        state_d = dsh_pkg::ST_OUT;
      end
      dsh_pkg::ST_READ: begin
        if (nb_q == 3'd4) begin
          state_d = dsh_pkg::ST_MUL1;
        end else begin
          pend_d = nb_ok;
          if (nb_ok) begin
            cnt_d = cnt_q + 1'b1;
          end
          nb_d = nb_q + 1'b1;
        end
      end
      dsh_pkg::ST_MUL1: begin
        prod1_d = P1W'(rough_q) * P1W'(hs_q);
        neg_d   = !u_q[15];
        absd_d  = u_q[15] ? {u_q, 1'b0} - 17'h10000 : 17'h10000 - {u_q, 1'b0};
        state_d = dsh_pkg::ST_MUL2;
      end
      dsh_pkg::ST_MUL2: begin
        prod2_d = P2W'(prod1_q) * P2W'(absd_q);
        state_d = dsh_pkg::ST_ADD;
      end
      dsh_pkg::ST_ADD: begin
        offm    = TW'(prod2_q[P2W-1:20]);
        tot_d   = neg_q ? sum_q - $signed(offm) : sum_q + $signed(offm);
        state_d = dsh_pkg::ST_DIV;
        div_start = 1'b1;
      end
      dsh_pkg::ST_DIV: begin
        if (div_done) begin
          val = tot_q[TW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          if (val > (TW+1)'(HMax)) begin
            h_d = HMax;
          end else if (val < (TW+1)'(HMin)) begin
            h_d = HMin;
          end else begin
            h_d = val[31:0];
          end
          state_d = dsh_pkg::ST_OUT;
        end
      end
      dsh_pkg::ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          mem_we  = 1'b1;
          ov_d    = 1'b1;
          oc_d    = col_q[8:0];
          or_d    = row_q[8:0];
          oh_d    = h_q;
          odone_d = 1'b0;
          state_d = dsh_pkg::ST_IDLE;
          if (phase_q == dsh_pkg::PhSeed) begin
            olo_d = min_q;
            ohi_d = max_q;
            if (col_q == '0 && row_q == '0) begin
              col_d = side - 1'b1;
            end else if (row_q == '0) begin
              col_d = '0;
              row_d = side - 1'b1;
            end else if (col_q == '0) begin
              col_d = side - 1'b1;
            end else begin
              seeded_d = 1'b1;
              phase_d  = dsh_pkg::PhSquare;
              col_d    = CW'(hs_q);
              row_d    = CW'(hs_q);
            end
          end else begin
            nmin  = (h_q < min_q) ? h_q : min_q;
            nmax  = (h_q > max_q) ? h_q : max_q;
            min_d = nmin;
            max_d = nmax;
            olo_d = nmin;
            ohi_d = nmax;
            if (phase_q == dsh_pkg::PhSquare) begin
              if (xe + (hse << 1) < ne) begin
                col_d = CW'(xe + (hse << 1));
              end else if (ze + (hse << 1) < ne) begin
                col_d = CW'(hs_q);
                row_d = CW'(ze + (hse << 1));
              end else begin
                phase_d = dsh_pkg::PhDiamond;
                col_d   = '0;
                row_d   = CW'(hs_q);
              end
            end else if (ze + (hse << 1) < ne) begin
              row_d = CW'(ze + (hse << 1));
            end else if (xe + hse < ne) begin
              ncol  = xe + hse;
              col_d = CW'(ncol);
              row_d = ((ncol & hse) != '0) ? '0 : CW'(hs_q);
            end else if ((hs_q >> 1) != '0) begin
              hs_d    = hs_q >> 1;
              phase_d = dsh_pkg::PhSquare;
              col_d   = CW'(hs_q >> 1);
              row_d   = CW'(hs_q >> 1);
            end else begin
              // last point of the run: restart at the top level, map kept
              odone_d = 1'b1;
              hs_d    = HW'(HW'(1) << (size_log_q - 1'b1));
              min_d   = HMax;
              max_d   = HMin;
              phase_d = dsh_pkg::PhSquare;
              col_d   = CW'(HW'(1) << (size_log_q - 1'b1));
              row_d   = CW'(HW'(1) << (size_log_q - 1'b1));
            end
          end
        end
      end
      default: state_d = dsh_pkg::ST_IDLE;
    endcase

    // configuration, written only while idle
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == dsh_pkg::CfgSizeLog) begin
        lnew = cfg_data_i[3:0];
        if (lnew < dsh_pkg::SizeLogMin) begin
          lnew = dsh_pkg::SizeLogMin;
        end
        if (lnew > 4'(MAX_LOG)) begin
          lnew = 4'(MAX_LOG);
        end
        size_log_d = lnew;
        seeded_d   = 1'b0;
        hs_d       = HW'(HW'(1) << (lnew - 1'b1));
        min_d      = HMax;
        max_d      = HMin;
        phase_d    = dsh_pkg::PhSeed;
        col_d      = '0;
        row_d      = '0;
      end else if (cfg_index_i == dsh_pkg::CfgRoughness) begin
        rough_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dsh_pkg::ST_IDLE;
      size_log_q <= dsh_pkg::SizeLogReset;
      rough_q    <= dsh_pkg::RoughReset;
      hs_q       <= HW'(HW'(1) << (dsh_pkg::SizeLogReset - 1'b1));
      phase_q    <= dsh_pkg::PhSeed;
      col_q      <= '0;
      row_q      <= '0;
      seeded_q   <= 1'b0;
      min_q      <= HMax;
      max_q      <= HMin;
      nb_q       <= '0;
      pend_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      size_log_q <= size_log_d;
      rough_q    <= rough_d;
      hs_q       <= hs_d;
      phase_q    <= phase_d;
      col_q      <= col_d;
      row_q      <= row_d;
      seeded_q   <= seeded_d;
      min_q      <= min_d;
      max_q      <= max_d;
      nb_q       <= nb_d;
      pend_q     <= pend_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    absd_q  <= absd_d;
    neg_q   <= neg_d;
    tot_q   <= tot_d;
    h_q     <= h_d;
    oc_q    <= oc_d;
    or_q    <= or_d;
    oh_q    <= oh_d;
    olo_q   <= olo_d;
    ohi_q   <= ohi_d;
    odone_q <= odone_d;
  end

  assign cfg_ready_o = (state_q == dsh_pkg::ST_IDLE);
  assign out_valid_o = ov_q;
  assign col_o       = oc_q;
  assign row_o       = or_q;
  assign height_o    = oh_q;
  assign low_mark_o  = olo_q;
  assign high_mark_o = ohi_q;
  assign run_done_o  = odone_q;

endmodule

// File: design/dsh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_div
// Divides a signed total by a neighbor count (3 or 4; 2 halves, others pass
// unscaled), magnitude out: magnitude, split products, reciprocal correction.
// ----------------------------------------------------------------------------
module dsh_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [dsh_pkg::TotW-1:0] dvd_i,
  input  logic [2:0]                      dvs_i,
  output logic                            done_o,
  output logic [dsh_pkg::TotW-1:0]        quo_o
);

  localparam int unsigned TW     = dsh_pkg::TotW;
  localparam int unsigned HiW    = TW - 16;               // upper part of the magnitude
  localparam int unsigned YW     = HiW + 1;               // upper plus lower part
  localparam logic [14:0] ThirdK = 15'd21845;             // (2^16 - 1) / 3
  localparam logic [YW-1:0] ThirdM = YW'(1398102);        // (2^22 + 2) / 3
  localparam int unsigned ThirdS = 22;

  logic              v1_q, v2_q, done_q;
  logic [TW-1:0]     mag_q, mag_d;
  logic [2:0]        dvs_q;
  logic [TW-1:0]     hi_q, hi_d;
  logic [YW-1:0]     y_q, y_d;
  logic [TW-1:0]     quo_q, quo_d;

  always_comb begin
    logic [HiW-1:0]  mh;
    logic [HiW+14:0] hp;
    logic [2*YW-1:0] yp;
    mag_d = dvd_i[TW-1] ? TW'(-dvd_i) : TW'(dvd_i);
    mh    = mag_q[TW-1:16];
    hp    = (HiW+15)'(mh) * (HiW+15)'(ThirdK);
    unique case (dvs_q)
      3'd3: begin
        // x = hi * 2^16 + lo, so x / 3 = hi * 21845 + (hi + lo) / 3
        hi_d = TW'(hp);
        y_d  = YW'(mh) + YW'(mag_q[15:0]);
      end
      3'd4: begin
        hi_d = mag_q >> 2;
        y_d  = '0;
      end
      3'd2: begin
        hi_d = mag_q >> 1;
        y_d  = '0;
      end
      default: begin
        // any other count: total passes unscaled
        hi_d = mag_q;
        y_d  = '0;
      end
    endcase
    yp    = (2*YW)'(y_q) * (2*YW)'(ThirdM);
    quo_d = hi_q + TW'(yp[2*YW-1:ThirdS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_d;
      dvs_q <= dvs_i;
    end
    if (v1_q) begin
      hi_q <= hi_d;
      y_q  <= y_d;
    end
    if (v2_q) begin
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: verif/diamond_square_heightmap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap_tb
// Self-checking bench for the diamond-square heightmap generator.
// A built-in walker mirrors the map, the walk order and the marks. It
// predicts every point, and each result is checked field by field in order.
// Map sizes and roughness change between phases, out-of-range sizes and the
// unused register indexes among them. Random idling runs on both channels,
// and one long receiver hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_tb;

  localparam int unsigned MapCap   = 257 * 257;
  localparam logic [1:0]  CfgSpareA = 2'd2;  // unused indexes, writes are ignored
  localparam logic [1:0]  CfgSpareB = 2'd3;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [8:0]         col;
    logic [8:0]         row;
    logic signed [31:0] height;
    logic signed [31:0] low_mark;
    logic signed [31:0] high_mark;
    logic               run_done;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid, cfg_ready_o;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready_o;
  logic [15:0] sample;
  logic out_valid_o, out_ready;
  logic [8:0] col_o, row_o;
  logic signed [31:0] height_o, low_mark_o, high_mark_o;
  logic run_done_o;

  // Mirror of the generator state.
  int          terrain [MapCap];
  int unsigned size_log, rough, reach, walk_ph, wcol, wrow;
  bit          seeded;
  int          lo_mark, hi_mark;

  logic [15:0] pending_samples[$];
  point_t      expected_points[$];
  int unsigned errors, items_sent, points_seen, runs_seen, reg_writes, hold_cnt;
  bit          hold_done;

  diamond_square_heightmap i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .col_o       (col_o),
    .row_o       (row_o),
    .height_o    (height_o),
    .low_mark_o  (low_mark_o),
    .high_mark_o (high_mark_o),
    .run_done_o  (run_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned side();
    return (1 << size_log) + 1;
  endfunction

  function automatic longint height_at(int unsigned c, int unsigned r);
    int unsigned idx;
    idx = r * side() + c;
    return (idx < MapCap) ? longint'(terrain[idx]) : longint'(terrain[0]);
  endfunction

  // New run: marks back to extremes, walk from corners or from the first square.
  task automatic restart_walk();
    reach   = (side() - 1) / 2;
    lo_mark = 32'sh7FFF_FFFF;
    hi_mark = 32'sh8000_0000;
    if (seeded) begin
      walk_ph = dsh_pkg::PhSquare;
      wcol    = reach;
      wrow    = reach;
    end else begin
      walk_ph = dsh_pkg::PhSeed;
      wcol    = 0;
      wrow    = 0;
    end
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [15:0] val);
    int unsigned v;
    if (idx == dsh_pkg::CfgSizeLog) begin
      v = val[3:0];
      if (v < 2) v = 2;
      if (v > dsh_pkg::MaxLogDefault) v = dsh_pkg::MaxLogDefault;
      size_log = v;
      seeded   = 1'b0;
      restart_walk();
    end else if (idx == dsh_pkg::CfgRoughness) begin
      rough = val;
    end
  endtask

  // Writes one map point for sample u and queues the expected result.
  task automatic carve_point(input logic [15:0] u);
    int unsigned n, hs, x, z, cnt;
    longint sum, d, off, tot, val;
    longint unsigned mag;
    int h, lo, hi;
    bit done;
    point_t p;
    n = side(); hs = reach; x = wcol; z = wrow;
    done = 1'b0; sum = 0; cnt = 0;
    if (walk_ph == dsh_pkg::PhSeed) begin
      h = int'((longint'(u) * n) >>> 8);
      terrain[z * n + x] = h;
      lo = lo_mark; hi = hi_mark;
      if (x == 0 && z == 0) wcol = n - 1;
      else if (z == 0) begin
        wcol = 0; wrow = n - 1;
      end else if (x == 0) wcol = n - 1;
      else begin
        seeded = 1'b1; walk_ph = dsh_pkg::PhSquare; wcol = hs; wrow = hs;
      end
    end else begin
      if (walk_ph == dsh_pkg::PhSquare) begin
        if (x >= hs) begin
          if (z >= hs) begin sum += height_at(x - hs, z - hs); cnt++; end
          if (z + hs < n) begin sum += height_at(x - hs, z + hs); cnt++; end
        end
        if (x + hs < n) begin
          if (z >= hs) begin sum += height_at(x + hs, z - hs); cnt++; end
          if (z + hs < n) begin sum += height_at(x + hs, z + hs); cnt++; end
        end
      end else begin
        if (x >= hs) begin sum += height_at(x - hs, z); cnt++; end
        if (x + hs < n) begin sum += height_at(x + hs, z); cnt++; end
        if (z >= hs) begin sum += height_at(x, z - hs); cnt++; end
        if (z + hs < n) begin sum += height_at(x, z + hs); cnt++; end
      end
      d   = 2 * longint'(u) - 65536;
      mag = (longint'(rough) * hs * ((d < 0) ? -d : d)) >> 20;
      off = (d < 0) ? -longint'(mag) : longint'(mag);
      tot = sum + off;
      val = (cnt != 0) ? tot / longint'(cnt) : tot;
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      h = int'(val);
      terrain[z * n + x] = h;
      if (h < lo_mark) lo_mark = h;
      if (h > hi_mark) hi_mark = h;
      lo = lo_mark; hi = hi_mark;
      if (walk_ph == dsh_pkg::PhSquare) begin
        if (x + 2 * hs < n) wcol = x + 2 * hs;
        else if (z + 2 * hs < n) begin
          wcol = hs; wrow = z + 2 * hs;
        end else begin
          walk_ph = dsh_pkg::PhDiamond; wcol = 0; wrow = hs;
        end
      end else if (z + 2 * hs < n) begin
        wrow = z + 2 * hs;
      end else if (x + hs < n) begin
        wcol = x + hs;
        wrow = ((wcol & hs) != 0) ? 0 : hs;
      end else if ((hs >> 1) != 0) begin
        reach = hs >> 1; walk_ph = dsh_pkg::PhSquare; wcol = reach; wrow = reach;
      end else begin
        done = 1'b1;
        restart_walk();
      end
    end
    p.col = x[8:0]; p.row = z[8:0]; p.height = h;
    p.low_mark = lo; p.high_mark = hi; p.run_done = done;
    expected_points.push_back(p);
  endtask

  // Long stretch with no idling on either side.
  function automatic bit quiet_zone();
    return items_sent >= 260 && items_sent < 380;
  endfunction

  // Driver: takes items from the pending queue, holds them until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sample   <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        carve_point(sample);
        items_sent++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_samples.size() > 0 && (quiet_zone() || $urandom_range(99) >= 11)) begin
          in_valid <= 1'b1;
          sample   <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (!hold_done && points_seen == 150) begin
      out_ready <= 1'b0;
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet_zone() || ($urandom_range(99) >= 11);
    end
  end

  // Monitor: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      points_seen++;
      if (run_done_o) runs_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point col=%0d row=%0d height=%0d",
                 $time, col_o, row_o, height_o);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (col_o !== e.col) begin
          $display("%0t: col exp %0d got %0d", $time, e.col, col_o); errors++;
        end
        if (row_o !== e.row) begin
          $display("%0t: row exp %0d got %0d", $time, e.row, row_o); errors++;
        end
        if (height_o !== e.height) begin
          $display("%0t: height exp %0d got %0d", $time, e.height, height_o); errors++;
        end
        if (low_mark_o !== e.low_mark) begin
          $display("%0t: low_mark exp %0d got %0d", $time, e.low_mark, low_mark_o);
          errors++;
        end
        if (high_mark_o !== e.high_mark) begin
          $display("%0t: high_mark exp %0d got %0d", $time, e.high_mark, high_mark_o);
          errors++;
        end
        if (run_done_o !== e.run_done) begin
          $display("%0t: run_done exp %0b got %0b", $time, e.run_done, run_done_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
  endtask

  // Lets the block drain before the next register write.
  task automatic settle();
    while (pending_samples.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0:       pending_samples.push_back(16'h0000);
        1:       pending_samples.push_back(16'hFFFF);
        default: pending_samples.push_back(16'($urandom_range(65535)));
      endcase
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dsh_pkg::CfgSizeLog;
    cfg_data  = '0;
    errors = 0; items_sent = 0; points_seen = 0; runs_seen = 0; reg_writes = 0;
    size_log = dsh_pkg::SizeLogReset;
    rough    = dsh_pkg::RoughReset;
    seeded   = 1'b0;
    restart_walk();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, corner seeding with extreme and midpoint fractions.
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h7FFF);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'hFFFE);
    pending_samples.push_back(16'hAAAA);
    pending_samples.push_back(16'h5555);
    queue_random(12);
    settle();

    // Smallest map, no roughness: a full run and the reused-map run after it.
    write_reg(dsh_pkg::CfgSizeLog, 16'd2);
    write_reg(dsh_pkg::CfgRoughness, 16'd0);
    queue_random(46);
    settle();

    // Largest roughness; unused register indexes must change nothing.
    write_reg(dsh_pkg::CfgRoughness, 16'hFFFF);
    write_reg(CfgSpareA, 16'h1234);
    write_reg(CfgSpareB, 16'hFFFF);
    queue_random(60);
    settle();

    // Size below range clamps to the smallest map and reseeds.
    write_reg(dsh_pkg::CfgSizeLog, 16'd0);
    write_reg(dsh_pkg::CfgRoughness, 16'd4096);
    queue_random(50);
    settle();

    write_reg(dsh_pkg::CfgSizeLog, 16'd3);
    write_reg(dsh_pkg::CfgRoughness, 16'd12000);
    queue_random(170);
    settle();

    // Size above range clamps to the largest map: a partial run only.
    write_reg(dsh_pkg::CfgSizeLog, 16'hFFFF);
    write_reg(dsh_pkg::CfgRoughness, 16'd300);
    queue_random(30);
    settle();

    write_reg(dsh_pkg::CfgSizeLog, 16'd4);
    write_reg(dsh_pkg::CfgRoughness, 16'($urandom_range(65535)));
    queue_random(180);
    settle();

    $display("Covered %0d items, %0d points checked, %0d full map runs, %0d register writes",
             items_sent, points_seen, runs_seen, reg_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout with %0d points still expected", expected_points.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
